/* hdl/rational_arithmetic_unit_macros.svh */
// Assertion macros used by the checker file of the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RAU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rau_pkg.sv */
package rau_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int FIELD_W       = 32;
    localparam int OPC_W         = 3;
    localparam int ERR_W         = 2;
    localparam int PROD_W        = 2 * OPERAND_WIDTH;
    localparam int CNT_W         = $clog2(PROD_W);
    localparam int RES_NUM_W     = 64;
    localparam int RES_DEN_W     = 63;

    localparam logic [OPC_W-1:0] OPC_ADD = OPC_W'(0);
    localparam logic [OPC_W-1:0] OPC_SUB = OPC_W'(1);
    localparam logic [OPC_W-1:0] OPC_MUL = OPC_W'(2);
    localparam logic [OPC_W-1:0] OPC_DIV = OPC_W'(3);
    localparam logic [OPC_W-1:0] OPC_NEG = OPC_W'(4);
    localparam logic [OPC_W-1:0] OPC_CMP = OPC_W'(5);

    localparam logic [ERR_W-1:0] ERR_NONE     = ERR_W'(0);
    localparam logic [ERR_W-1:0] ERR_DIV_ZERO = ERR_W'(1);
    localparam logic [ERR_W-1:0] ERR_ZERO_DEN = ERR_W'(2);

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_SET_ERR,
        DP_ZERO_FIX,
        DP_GCD_START,
        DP_DIV_START,
        DP_DIV_WB,
        DP_MUL,
        DP_X_FROM_P,
        DP_Y_FROM_P,
        DP_SUM,
        DP_R_N_FROM_P,
        DP_R_D_FROM_P,
        DP_CMP,
        DP_NEG,
        DP_OUT_LOAD
    } t_dp_op;

    // Which fraction a reduction works on.
    typedef enum logic [1:0] {
        RED_A,
        RED_B,
        RED_R
    } t_red_sel;

    typedef enum logic [2:0] {
        MUL_AN_BD,
        MUL_BN_AD,
        MUL_AD_BD,
        MUL_AN_BN,
        MUL_AD_BN
    } t_mul_sel;

    typedef struct packed {
        t_dp_op           op;
        t_red_sel         red;
        t_mul_sel         mul;
        logic [ERR_W-1:0] err;
    } t_dp_cmd;

    typedef struct packed {
        logic [OPC_W-1:0] opcode;
        logic             a_den_zero;
        logic             b_den_zero;
        logic             a_n_zero;
        logic             b_n_zero;
        logic             r_n_zero;
        logic             gcd_done;
        logic             div_done;
    } t_dp_sts;

endpackage

/* hdl/rau_if.sv */
interface rau_in_if;
    logic                                valid;
    logic                                ready;
    logic [rau_pkg::OPC_W-1:0]           opcode;
    logic signed [rau_pkg::FIELD_W-1:0]  a_num;
    logic signed [rau_pkg::FIELD_W-1:0]  a_den;
    logic signed [rau_pkg::FIELD_W-1:0]  b_num;
    logic signed [rau_pkg::FIELD_W-1:0]  b_den;

    modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
    modport sink (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rau_pkg::RES_NUM_W-1:0] res_num;
    logic [rau_pkg::RES_DEN_W-1:0]        res_den;
    logic                                 less_flag;
    logic                                 equal_flag;
    logic [rau_pkg::ERR_W-1:0]            error_code;

    modport source (output valid, res_num, res_den, less_flag, equal_flag, error_code,
                    input ready);
    modport sink (input valid, res_num, res_den, less_flag, equal_flag, error_code,
                  output ready);
endinterface

/* hdl/rau_gcd.sv */
module rau_gcd (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rau_pkg::PROD_W-1:0] i_x,
    input  logic [rau_pkg::PROD_W-1:0] i_y,
    output logic                       o_done,
    output logic [rau_pkg::PROD_W-1:0] o_g
);

    localparam int DW = rau_pkg::PROD_W;
    localparam int KW = rau_pkg::CNT_W;

    logic [DW-1:0] r_x, n_x;
    logic [DW-1:0] r_y, n_y;
    logic [DW-1:0] r_g, n_g;
    logic [KW-1:0] r_k, n_k;
    logic          r_busy, n_busy;
    logic          r_done, n_done;

    // Binary GCD, one step per cycle. Common factors of two are counted in
    // r_k and shifted back in at the end.
    always_comb begin
        n_x    = r_x;
        n_y    = r_y;
        n_k    = r_k;
        n_g    = r_g;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_x    = i_x;
            n_y    = i_y;
            n_k    = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_x == '0) begin
                n_g    = r_y << r_k;
                n_busy = 1'b0;
                n_done = 1'b1;
            end else if (r_y == '0) begin
                n_g    = r_x << r_k;
                n_busy = 1'b0;
                n_done = 1'b1;
            end else if (!r_x[0] && !r_y[0]) begin
                n_x = r_x >> 1;
                n_y = r_y >> 1;
                n_k = r_k + KW'(1);
            end else if (!r_x[0]) begin
                n_x = r_x >> 1;
            end else if (!r_y[0]) begin
                n_y = r_y >> 1;
            end else if (r_x >= r_y) begin
                n_x = (r_x - r_y) >> 1;
            end else begin
                n_y = (r_y - r_x) >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_k <= n_k;
        r_g <= n_g;
    end

    assign o_done = r_done;
    assign o_g    = r_g;

endmodule

/* hdl/rau_div.sv */
module rau_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rau_pkg::PROD_W-1:0] i_n0,
    input  logic [rau_pkg::PROD_W-1:0] i_n1,
    input  logic [rau_pkg::PROD_W-1:0] i_dv,
    output logic                       o_done,
    output logic [rau_pkg::PROD_W-1:0] o_q0,
    output logic [rau_pkg::PROD_W-1:0] o_q1
);

    localparam int DW = rau_pkg::PROD_W;
    localparam int KW = rau_pkg::CNT_W;

    logic [DW-1:0] r_rem [2];
    logic [DW-1:0] n_rem [2];
    logic [DW-1:0] r_quo [2];
    logic [DW-1:0] n_quo [2];
    logic [DW:0]   trial [2];
    logic [DW:0]   diff  [2];
    logic [DW-1:0] r_dv, n_dv;
    logic [KW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;

    // Two restoring dividers share the divisor and the bit counter; each
    // cycle shifts one dividend bit into the remainder and one quotient bit
    // into the low end of the dividend register.
    always_comb begin
        n_dv   = r_dv;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        for (int l = 0; l < 2; l++) begin
            trial[l] = {r_rem[l], r_quo[l][DW-1]};
            diff[l]  = trial[l] - {1'b0, r_dv};
            n_rem[l] = r_rem[l];
            n_quo[l] = r_quo[l];
        end
        if (i_start) begin
            n_dv     = i_dv;
            n_cnt    = KW'(DW - 1);
            n_busy   = 1'b1;
            n_rem[0] = '0;
            n_rem[1] = '0;
            n_quo[0] = i_n0;
            n_quo[1] = i_n1;
        end else if (r_busy) begin
            for (int l = 0; l < 2; l++) begin
                if (!diff[l][DW]) begin
                    n_rem[l] = diff[l][DW-1:0];
                end else begin
                    n_rem[l] = trial[l][DW-1:0];
                end
                n_quo[l] = {r_quo[l][DW-2:0], !diff[l][DW]};
            end
            n_cnt = r_cnt - KW'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv  <= n_dv;
        r_cnt <= n_cnt;
        for (int l = 0; l < 2; l++) begin
            r_rem[l] <= n_rem[l];
            r_quo[l] <= n_quo[l];
        end
    end

    assign o_done = r_done;
    assign o_q0   = r_quo[0];
    assign o_q1   = r_quo[1];

endmodule

/* hdl/rau_dp.sv */
module rau_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  rau_pkg::t_dp_cmd                     i_cmd,
    output rau_pkg::t_dp_sts                     o_sts,
    input  logic [rau_pkg::OPC_W-1:0]            i_opcode,
    input  logic signed [rau_pkg::FIELD_W-1:0]   i_a_num,
    input  logic signed [rau_pkg::FIELD_W-1:0]   i_a_den,
    input  logic signed [rau_pkg::FIELD_W-1:0]   i_b_num,
    input  logic signed [rau_pkg::FIELD_W-1:0]   i_b_den,
    output logic signed [rau_pkg::RES_NUM_W-1:0] o_res_num,
    output logic [rau_pkg::RES_DEN_W-1:0]        o_res_den,
    output logic                                 o_less_flag,
    output logic                                 o_equal_flag,
    output logic [rau_pkg::ERR_W-1:0]            o_error_code
);

    localparam int W  = rau_pkg::OPERAND_WIDTH;
    localparam int PW = rau_pkg::PROD_W;
    localparam int NW = rau_pkg::RES_NUM_W;

    // Sign and magnitude of the low W bits of a field; the magnitude of the
    // most negative value is exact in W unsigned bits.
    function automatic logic [W:0] split_field(input logic [rau_pkg::FIELD_W-1:0] raw);
        logic [W-1:0] v;
        v = raw[W-1:0];
        return {v[W-1], v[W-1] ? (~v + W'(1)) : v};
    endfunction

    logic [rau_pkg::OPC_W-1:0] r_opcode;
    logic                      r_a_neg, r_b_neg;
    logic [W-1:0]              r_a_n, r_a_d, r_b_n, r_b_d;
    logic                      r_a_dz, r_b_dz;
    logic [PW-1:0]             r_p;
    logic signed [PW-1:0]      r_x, r_y;
    logic                      r_r_neg;
    logic [PW-1:0]             r_r_n, r_r_d;
    logic                      r_less, r_equal;
    logic [rau_pkg::ERR_W-1:0] r_err;

    logic signed [NW-1:0]            r_o_num;
    logic [rau_pkg::RES_DEN_W-1:0]   r_o_den;
    logic                            r_o_less, r_o_equal;
    logic [rau_pkg::ERR_W-1:0]       r_o_err;

    logic [W:0]           sa_n, sa_d, sb_n, sb_d;
    logic [W-1:0]         mul_l, mul_r;
    logic [PW-1:0]        prod;
    logic signed [PW-1:0] sum;
    logic [PW-1:0]        sum_mag;
    logic [PW-1:0]        red_n, red_d;
    logic [NW-1:0]        num_ext, den_ext;
    logic                 gcd_start, gcd_done, div_start, div_done;
    logic [PW-1:0]        gcd_g, q0, q1;

    assign sa_n = split_field($unsigned(i_a_num));
    assign sa_d = split_field($unsigned(i_a_den));
    assign sb_n = split_field($unsigned(i_b_num));
    assign sb_d = split_field($unsigned(i_b_den));

    always_comb begin
        unique case (i_cmd.mul)
            rau_pkg::MUL_AN_BD: begin mul_l = r_a_n; mul_r = r_b_d; end
            rau_pkg::MUL_BN_AD: begin mul_l = r_b_n; mul_r = r_a_d; end
            rau_pkg::MUL_AD_BD: begin mul_l = r_a_d; mul_r = r_b_d; end
            rau_pkg::MUL_AN_BN: begin mul_l = r_a_n; mul_r = r_b_n; end
            rau_pkg::MUL_AD_BN: begin mul_l = r_a_d; mul_r = r_b_n; end
            default:            begin mul_l = r_a_n; mul_r = r_b_d; end
        endcase
    end

    assign prod = PW'(mul_l) * PW'(mul_r);

    // Cross products never exceed the int64 range for reduced operands, so
    // the two's complement sum is exact.
    assign sum     = (r_opcode == rau_pkg::OPC_SUB) ? (r_x - r_y) : (r_x + r_y);
    assign sum_mag = sum[PW-1] ? $unsigned(-sum) : $unsigned(sum);

    always_comb begin
        unique case (i_cmd.red)
            rau_pkg::RED_A: begin red_n = PW'(r_a_n); red_d = PW'(r_a_d); end
            rau_pkg::RED_B: begin red_n = PW'(r_b_n); red_d = PW'(r_b_d); end
            default:        begin red_n = r_r_n;      red_d = r_r_d;      end
        endcase
    end

    assign gcd_start = (i_cmd.op == rau_pkg::DP_GCD_START);
    assign div_start = (i_cmd.op == rau_pkg::DP_DIV_START);

    rau_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (gcd_start),
        .i_x     (red_n),
        .i_y     (red_d),
        .o_done  (gcd_done),
        .o_g     (gcd_g)
    );

    rau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_n0    (red_n),
        .i_n1    (red_d),
        .i_dv    (gcd_g),
        .o_done  (div_done),
        .o_q0    (q0),
        .o_q1    (q1)
    );

    assign num_ext = NW'(r_r_n);
    assign den_ext = NW'(r_r_d);

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            rau_pkg::DP_LOAD: begin
                r_opcode <= i_opcode;
                r_a_neg  <= (sa_n[W-1:0] != '0) && (sa_n[W] != sa_d[W]);
                r_a_n    <= sa_n[W-1:0];
                r_a_d    <= sa_d[W-1:0];
                r_a_dz   <= (sa_d[W-1:0] == '0);
                r_b_neg  <= (sb_n[W-1:0] != '0) && (sb_n[W] != sb_d[W]);
                r_b_n    <= sb_n[W-1:0];
                r_b_d    <= sb_d[W-1:0];
                r_b_dz   <= (sb_d[W-1:0] == '0);
                r_r_neg  <= 1'b0;
                r_r_n    <= '0;
                r_r_d    <= PW'(1);
                r_less   <= 1'b0;
                r_equal  <= 1'b0;
                r_err    <= rau_pkg::ERR_NONE;
            end
            rau_pkg::DP_SET_ERR: r_err <= i_cmd.err;
            rau_pkg::DP_ZERO_FIX: begin
                unique case (i_cmd.red)
                    rau_pkg::RED_A: begin r_a_neg <= 1'b0; r_a_d <= W'(1); end
                    rau_pkg::RED_B: begin r_b_neg <= 1'b0; r_b_d <= W'(1); end
                    default:        begin r_r_neg <= 1'b0; r_r_d <= PW'(1); end
                endcase
            end
            rau_pkg::DP_DIV_WB: begin
                unique case (i_cmd.red)
                    rau_pkg::RED_A: begin r_a_n <= q0[W-1:0]; r_a_d <= q1[W-1:0]; end
                    rau_pkg::RED_B: begin r_b_n <= q0[W-1:0]; r_b_d <= q1[W-1:0]; end
                    default:        begin r_r_n <= q0;        r_r_d <= q1;        end
                endcase
            end
            rau_pkg::DP_MUL:      r_p <= prod;
            rau_pkg::DP_X_FROM_P: r_x <= r_a_neg ? -$signed(r_p) : $signed(r_p);
            rau_pkg::DP_Y_FROM_P: r_y <= r_b_neg ? -$signed(r_p) : $signed(r_p);
            rau_pkg::DP_SUM: begin
                r_r_neg <= sum[PW-1];
                r_r_n   <= sum_mag;
            end
            rau_pkg::DP_R_N_FROM_P: begin
                r_r_neg <= r_a_neg ^ r_b_neg;
                r_r_n   <= r_p;
            end
            rau_pkg::DP_R_D_FROM_P: r_r_d <= r_p;
            rau_pkg::DP_CMP: begin
                r_less  <= (r_x < r_y);
                r_equal <= (r_x == r_y);
            end
            rau_pkg::DP_NEG: begin
                r_r_neg <= (r_a_n != '0) && !r_a_neg;
                r_r_n   <= PW'(r_a_n);
                r_r_d   <= PW'(r_a_d);
            end
            rau_pkg::DP_OUT_LOAD: begin
                r_o_num   <= r_r_neg ? $signed(-num_ext) : $signed(num_ext);
                r_o_den   <= den_ext[rau_pkg::RES_DEN_W-1:0];
                r_o_less  <= r_less;
                r_o_equal <= r_equal;
                r_o_err   <= r_err;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_sts.opcode     = r_opcode;
        o_sts.a_den_zero = r_a_dz;
        o_sts.b_den_zero = r_b_dz;
        o_sts.a_n_zero   = (r_a_n == '0);
        o_sts.b_n_zero   = (r_b_n == '0);
        o_sts.r_n_zero   = (r_r_n == '0);
        o_sts.gcd_done   = gcd_done;
        o_sts.div_done   = div_done;
    end

    assign o_res_num    = r_o_num;
    assign o_res_den    = r_o_den;
    assign o_less_flag  = r_o_less;
    assign o_equal_flag = r_o_equal;
    assign o_error_code = r_o_err;

endmodule

/* hdl/rau_ctrl.sv */
module rau_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output rau_pkg::t_dp_cmd o_cmd,
    input  rau_pkg::t_dp_sts i_sts
);

    localparam int STEP_W = 3;

    localparam rau_pkg::t_dp_cmd CMD_IDLE = '{
        op:  rau_pkg::DP_NOP,
        red: rau_pkg::RED_A,
        mul: rau_pkg::MUL_AN_BD,
        err: rau_pkg::ERR_NONE
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_RED_START,
        S_RED_GCD,
        S_RED_DIV,
        S_RED_END,
        S_OPER,
        S_PROG,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    rau_pkg::t_red_sel   r_tgt, n_tgt;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_out_valid, n_out_valid;
    rau_pkg::t_dp_cmd    prog_cmd;
    logic                prog_last;
    logic                tgt_n_zero;

    always_comb begin
        unique case (r_tgt)
            rau_pkg::RED_A: tgt_n_zero = i_sts.a_n_zero;
            rau_pkg::RED_B: tgt_n_zero = i_sts.b_n_zero;
            default:        tgt_n_zero = i_sts.r_n_zero;
        endcase
    end

    // Short multiply programs, one datapath command per step. The product
    // register is copied out in the step after each multiplication.
    always_comb begin
        prog_cmd  = CMD_IDLE;
        prog_last = 1'b0;
        unique case (i_sts.opcode) inside
            rau_pkg::OPC_ADD, rau_pkg::OPC_SUB, rau_pkg::OPC_CMP: begin
                case (r_step)
                    STEP_W'(0): begin
                        prog_cmd.op  = rau_pkg::DP_MUL;
                        prog_cmd.mul = rau_pkg::MUL_AN_BD;
                    end
                    STEP_W'(1): prog_cmd.op = rau_pkg::DP_X_FROM_P;
                    STEP_W'(2): begin
                        prog_cmd.op  = rau_pkg::DP_MUL;
                        prog_cmd.mul = rau_pkg::MUL_BN_AD;
                    end
                    STEP_W'(3): prog_cmd.op = rau_pkg::DP_Y_FROM_P;
                    STEP_W'(4): begin
                        if (i_sts.opcode == rau_pkg::OPC_CMP) begin
                            prog_cmd.op = rau_pkg::DP_CMP;
                            prog_last   = 1'b1;
                        end else begin
                            prog_cmd.op = rau_pkg::DP_SUM;
                        end
                    end
                    STEP_W'(5): begin
                        prog_cmd.op  = rau_pkg::DP_MUL;
                        prog_cmd.mul = rau_pkg::MUL_AD_BD;
                    end
                    default: begin
                        prog_cmd.op = rau_pkg::DP_R_D_FROM_P;
                        prog_last   = 1'b1;
                    end
                endcase
            end
            rau_pkg::OPC_MUL, rau_pkg::OPC_DIV: begin
                case (r_step)
                    STEP_W'(0): begin
                        prog_cmd.op  = rau_pkg::DP_MUL;
                        prog_cmd.mul = (i_sts.opcode == rau_pkg::OPC_MUL) ?
                                       rau_pkg::MUL_AN_BN : rau_pkg::MUL_AN_BD;
                    end
                    STEP_W'(1): prog_cmd.op = rau_pkg::DP_R_N_FROM_P;
                    STEP_W'(2): begin
                        prog_cmd.op  = rau_pkg::DP_MUL;
                        prog_cmd.mul = (i_sts.opcode == rau_pkg::OPC_MUL) ?
                                       rau_pkg::MUL_AD_BD : rau_pkg::MUL_AD_BN;
                    end
                    default: begin
                        prog_cmd.op = rau_pkg::DP_R_D_FROM_P;
                        prog_last   = 1'b1;
                    end
                endcase
            end
            default: prog_last = 1'b1;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_tgt       = r_tgt;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = CMD_IDLE;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = rau_pkg::DP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.opcode > rau_pkg::OPC_CMP) begin
                    n_state = S_DONE;
                end else if (i_sts.a_den_zero ||
                             (i_sts.opcode != rau_pkg::OPC_NEG && i_sts.b_den_zero)) begin
                    o_cmd.op  = rau_pkg::DP_SET_ERR;
                    o_cmd.err = rau_pkg::ERR_ZERO_DEN;
                    n_state   = S_DONE;
                end else begin
                    n_tgt   = rau_pkg::RED_A;
                    n_state = S_RED_START;
                end
            end
            S_RED_START: begin
                o_cmd.red = r_tgt;
                if (tgt_n_zero) begin
                    o_cmd.op = rau_pkg::DP_ZERO_FIX;
                    n_state  = S_RED_END;
                end else begin
                    o_cmd.op = rau_pkg::DP_GCD_START;
                    n_state  = S_RED_GCD;
                end
            end
            S_RED_GCD: begin
                o_cmd.red = r_tgt;
                if (i_sts.gcd_done) begin
                    o_cmd.op = rau_pkg::DP_DIV_START;
                    n_state  = S_RED_DIV;
                end
            end
            S_RED_DIV: begin
                o_cmd.red = r_tgt;
                if (i_sts.div_done) begin
                    o_cmd.op = rau_pkg::DP_DIV_WB;
                    n_state  = S_RED_END;
                end
            end
            S_RED_END: begin
                unique case (r_tgt)
                    rau_pkg::RED_A: begin
                        if (i_sts.opcode == rau_pkg::OPC_NEG) begin
                            n_state = S_OPER;
                        end else begin
                            n_tgt   = rau_pkg::RED_B;
                            n_state = S_RED_START;
                        end
                    end
                    rau_pkg::RED_B: n_state = S_OPER;
                    default:        n_state = S_DONE;
                endcase
            end
            S_OPER: begin
                n_step = '0;
                if (i_sts.opcode == rau_pkg::OPC_NEG) begin
                    o_cmd.op = rau_pkg::DP_NEG;
                    n_state  = S_DONE;
                end else if (i_sts.opcode == rau_pkg::OPC_DIV && i_sts.b_n_zero) begin
                    o_cmd.op  = rau_pkg::DP_SET_ERR;
                    o_cmd.err = rau_pkg::ERR_DIV_ZERO;
                    n_state   = S_DONE;
                end else begin
                    n_state = S_PROG;
                end
            end
            S_PROG: begin
                o_cmd  = prog_cmd;
                n_step = r_step + STEP_W'(1);
                if (prog_last) begin
                    if (i_sts.opcode == rau_pkg::OPC_CMP) begin
                        n_state = S_DONE;
                    end else begin
                        n_tgt   = rau_pkg::RED_R;
                        n_state = S_RED_START;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = rau_pkg::DP_OUT_LOAD;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tgt       <= rau_pkg::RED_A;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tgt       <= n_tgt;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* hdl/rational_arithmetic_unit.sv */
// Exact arithmetic on two signed fractions a = a_num/a_den and b = b_num/b_den:
// add, subtract, multiply, divide, negate a, and compare. The used operands are
// brought to lowest terms first, every arithmetic result is reduced by its GCD
// with the sign in res_num and res_den at least 1, and compare reports through
// less_flag and equal_flag with a 0/1 result. A zero denominator on a used
// operand gives 0/1 with error code 2, division by a zero b gives 0/1 with
// error code 1, and opcodes 6 and 7 give 0/1 with no error. One word is
// worked on at a time; a new word is taken while the previous result still
// waits in the output register. The shared binary GCD unit
// (one step per cycle) and the shared restoring divider (one quotient bit per
// cycle) together perform each reduction. A zero numerator skips both and
// only clears the sign and sets the denominator to 1. With nonzero numerators,
// add, subtract, multiply and divide run three reductions, compare runs two
// and negate one. Division by a zero b reduces a and b only. A zero operand
// denominator or an undefined opcode skips all reductions.
module rational_arithmetic_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rau_in_if.sink        i_op,
    rau_out_if.source     o_res
);

    logic             in_ready;
    logic             out_valid;
    rau_pkg::t_dp_cmd cmd;
    rau_pkg::t_dp_sts sts;

    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_op.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    rau_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_opcode     (i_op.opcode),
        .i_a_num      (i_op.a_num),
        .i_a_den      (i_op.a_den),
        .i_b_num      (i_op.b_num),
        .i_b_den      (i_op.b_den),
        .o_res_num    (o_res.res_num),
        .o_res_den    (o_res.res_den),
        .o_less_flag  (o_res.less_flag),
        .o_equal_flag (o_res.equal_flag),
        .o_error_code (o_res.error_code)
    );

    assign i_op.ready  = in_ready;
    assign o_res.valid = out_valid;

endmodule

/* hdl/rau_chk.sv */
`include "rational_arithmetic_unit_macros.svh"

module rau_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_out_valid,
    input logic                                 i_out_ready,
    input logic signed [rau_pkg::RES_NUM_W-1:0] i_res_num,
    input logic [rau_pkg::RES_DEN_W-1:0]        i_res_den,
    input logic                                 i_less_flag,
    input logic                                 i_equal_flag,
    input logic [rau_pkg::ERR_W-1:0]            i_error_code
);

    // A result word always carries a positive denominator.
    `RAU_ASSERT_NOW(a_den_nonzero, i_clk, i_rst_n, i_out_valid, i_res_den != '0, "res_den is zero")

    // Every error result is the canonical zero.
    `RAU_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, i_out_valid && i_error_code != rau_pkg::ERR_NONE, i_res_num == '0 && i_res_den == rau_pkg::RES_DEN_W'(1), "error result is not 0/1")

    // Compare flags come only from a clean compare, which returns 0/1.
    `RAU_ASSERT_NOW(a_flags_cmp, i_clk, i_rst_n, i_out_valid && (i_less_flag || i_equal_flag), !(i_less_flag && i_equal_flag) && i_res_num == '0 && i_res_den == rau_pkg::RES_DEN_W'(1) && i_error_code == rau_pkg::ERR_NONE, "bad compare result")

    // A stalled result word holds.
    `RAU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_res_num) && $stable(i_res_den), "stalled result changed")

endmodule

bind rational_arithmetic_unit rau_chk u_rau_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_res_num    (o_res.res_num),
    .i_res_den    (o_res.res_den),
    .i_less_flag  (o_res.less_flag),
    .i_equal_flag (o_res.equal_flag),
    .i_error_code (o_res.error_code)
);

/* tb/sv/tb.sv */
module tb;
    import rau_pkg::*;

    localparam logic [OPC_W-1:0] OPC_UNDEF_LO = OPC_W'(6);
    localparam logic [OPC_W-1:0] OPC_UNDEF_HI = OPC_W'(7);
    localparam int DRAIN_CYCLES = 600;

    typedef struct {
        logic [OPC_W-1:0]   opcode;
        logic [FIELD_W-1:0] a_num;
        logic [FIELD_W-1:0] a_den;
        logic [FIELD_W-1:0] b_num;
        logic [FIELD_W-1:0] b_den;
    } t_op_word;

    typedef struct {
        logic signed [RES_NUM_W-1:0] num;
        logic [RES_DEN_W-1:0]        den;
        logic                        less;
        logic                        equal;
        logic [ERR_W-1:0]            err;
    } t_result_word;

    // Sign and magnitude form of a fraction, magnitudes at full 64 bits.
    typedef struct {
        bit        neg;
        bit [63:0] n;
        bit [63:0] d;
    } t_frac;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rau_in_if  op_if ();
    rau_out_if res_if ();

    rational_arithmetic_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op_if),
        .o_res   (res_if)
    );

    t_result_word expected_results[$];
    int unsigned  mismatches;
    int unsigned  results_seen;
    bit           allow_idle;
    int unsigned  stall_left;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Exact fraction arithmetic used to predict every result word.
    // ------------------------------------------------------------------
    function automatic t_frac lowest_terms(t_frac f);
        bit [63:0] x;
        bit [63:0] y;
        bit [63:0] r;
        if (f.n == 64'd0) begin
            f.neg = 1'b0;
            f.d   = 64'd1;
            return f;
        end
        x = f.n;
        y = f.d;
        while (y != 64'd0) begin
            r = x % y;
            x = y;
            y = r;
        end
        if (x != 64'd0) begin
            f.n = f.n / x;
            f.d = f.d / x;
        end
        return f;
    endfunction

    // Returns 0 when the denominator is zero. Only the low OPERAND_WIDTH bits count.
    function automatic bit load_fraction(logic [FIELD_W-1:0] rn, logic [FIELD_W-1:0] rd,
                                         output t_frac f);
        bit [63:0] mask;
        bit [63:0] top;
        bit [63:0] vn;
        bit [63:0] vd;
        bit [63:0] mn;
        bit [63:0] md;
        bit        sn;
        bit        sd;
        mask = (64'd1 << OPERAND_WIDTH) - 64'd1;
        top  = 64'd1 << (OPERAND_WIDTH - 1);
        vn   = 64'(rn) & mask;
        vd   = 64'(rd) & mask;
        sn   = (vn & top) != 64'd0;
        sd   = (vd & top) != 64'd0;
        mn   = sn ? (mask + 64'd1) - vn : vn;
        md   = sd ? (mask + 64'd1) - vd : vd;
        f    = '{neg: 1'b0, n: 64'd0, d: 64'd1};
        if (md == 64'd0)
            return 1'b0;
        f.neg = (mn != 64'd0) && (sn != sd);
        f.n   = mn;
        f.d   = md;
        f     = lowest_terms(f);
        return 1'b1;
    endfunction

    function automatic longint signed_prod(bit neg, bit [63:0] m, bit [63:0] k);
        bit [63:0] p;
        p = m * k;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic t_result_word predict_result(t_op_word w);
        t_frac        a;
        t_frac        b;
        t_frac        r;
        bit           a_ok;
        bit           b_ok;
        longint       x;
        longint       y;
        longint       s;
        t_result_word e;
        a_ok = load_fraction(w.a_num, w.a_den, a);
        b_ok = load_fraction(w.b_num, w.b_den, b);
        r    = '{neg: 1'b0, n: 64'd0, d: 64'd1};
        e    = '{default: '0};
        if (w.opcode <= OPC_CMP) begin
            // A zero denominator on a used operand wins over division by zero.
            if (!a_ok || (w.opcode != OPC_NEG && !b_ok)) begin
                e.err = ERR_ZERO_DEN;
            end else begin
                case (w.opcode)
                    OPC_ADD, OPC_SUB: begin
                        x     = signed_prod(a.neg, a.n, b.d);
                        y     = signed_prod(b.neg, b.n, a.d);
                        s     = (w.opcode == OPC_ADD) ? x + y : x - y;
                        r.neg = s < 0;
                        r.n   = r.neg ? 64'(-s) : 64'(s);
                        r.d   = a.d * b.d;
                        r     = lowest_terms(r);
                    end
                    OPC_MUL: begin
                        r.neg = a.neg != b.neg;
                        r.n   = a.n * b.n;
                        r.d   = a.d * b.d;
                        r     = lowest_terms(r);
                    end
                    OPC_DIV: begin
                        if (b.n == 64'd0) begin
                            e.err = ERR_DIV_ZERO;
                        end else begin
                            r.neg = a.neg != b.neg;
                            r.n   = a.n * b.d;
                            r.d   = a.d * b.n;
                            r     = lowest_terms(r);
                        end
                    end
                    OPC_NEG: begin
                        r     = a;
                        r.neg = (a.n != 64'd0) && !a.neg;
                    end
                    OPC_CMP: begin
                        x       = signed_prod(a.neg, a.n, b.d);
                        y       = signed_prod(b.neg, b.n, a.d);
                        e.less  = x < y;
                        e.equal = x == y;
                    end
                    default: ;
                endcase
            end
        end
        e.num = r.neg ? 64'd0 - r.n : r.n;
        e.den = r.d[RES_DEN_W-1:0];
        return e;
    endfunction

    // ------------------------------------------------------------------
    // Source side: one word per call, with optional idle burst in front.
    // ------------------------------------------------------------------
    task automatic send_word(logic [OPC_W-1:0] opc, logic [FIELD_W-1:0] an,
                             logic [FIELD_W-1:0] ad, logic [FIELD_W-1:0] bn,
                             logic [FIELD_W-1:0] bd);
        t_op_word w;
        w = '{opcode: opc, a_num: an, a_den: ad, b_num: bn, b_den: bd};
        @(negedge i_clk);
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            op_if.valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        op_if.opcode = w.opcode;
        op_if.a_num  = w.a_num;
        op_if.a_den  = w.a_den;
        op_if.b_num  = w.b_num;
        op_if.b_den  = w.b_den;
        op_if.valid  = 1'b1;
        do @(posedge i_clk); while (!op_if.ready);
        expected_results.push_back(predict_result(w));
    endtask

    // Sink side: random stall bursts while idling is allowed, else always ready.
    initial begin
        res_if.ready = 1'b0;
        stall_left   = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                res_if.ready = 1'b0;
                stall_left   = stall_left - 1;
            end else if (allow_idle && $urandom_range(0, 5) == 0) begin
                res_if.ready = 1'b0;
                stall_left   = $urandom_range(1, 12) - 1;
            end else begin
                res_if.ready = 1'b1;
            end
        end
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches = mismatches + 1;
        if (mismatches <= 50)
            $display("mismatch on result %0d, %s: got %0h, expected %0h",
                     results_seen, what, got, want);
    endtask

    always @(posedge i_clk) begin : check_result
        t_result_word want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen = results_seen + 1;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected word", 64'(res_if.res_num), 64'd0);
            end else begin
                want = expected_results.pop_front();
                if (res_if.res_num !== want.num)
                    report_mismatch("res_num", 64'(res_if.res_num), 64'(want.num));
                if (res_if.res_den !== want.den)
                    report_mismatch("res_den", 64'(res_if.res_den), 64'(want.den));
                if (res_if.less_flag !== want.less)
                    report_mismatch("less_flag", 64'(res_if.less_flag), 64'(want.less));
                if (res_if.equal_flag !== want.equal)
                    report_mismatch("equal_flag", 64'(res_if.equal_flag), 64'(want.equal));
                if (res_if.error_code !== want.err)
                    report_mismatch("error_code", 64'(res_if.error_code), 64'(want.err));
            end
        end
    end

    // ------------------------------------------------------------------
    // Random operands: a mix of full-width values, small values that share
    // factors, and the extremes of the field.
    // ------------------------------------------------------------------
    function automatic logic [FIELD_W-1:0] random_operand();
        int s;
        int m;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return FIELD_W'($urandom);
            4, 5, 6: begin
                s = int'($urandom_range(0, 40)) - 20;
                return FIELD_W'(s);
            end
            7, 8: begin
                s = int'($urandom_range(0, 60)) - 30;
                m = int'($urandom_range(1, 5000));
                return FIELD_W'(s * m);
            end
            default: begin
                case ($urandom_range(0, 5))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h8000_0001;
                    3: return 32'hFFFF_FFFF;
                    4: return 32'h0000_0001;
                    default: return 32'h0000_0000;
                endcase
            end
        endcase
    endfunction

    function automatic logic [FIELD_W-1:0] random_denominator();
        logic [FIELD_W-1:0] d;
        if ($urandom_range(0, 39) == 0)
            return '0;
        d = random_operand();
        return (d == '0) ? FIELD_W'(1) : d;
    endfunction

    task automatic run_random(int unsigned count);
        logic [OPC_W-1:0]   opc;
        logic [FIELD_W-1:0] an;
        logic [FIELD_W-1:0] ad;
        logic [FIELD_W-1:0] bn;
        logic [FIELD_W-1:0] bd;
        int                 k;
        int                 sn;
        int                 sd;
        repeat (count) begin
            opc = ($urandom_range(0, 24) == 0) ? OPC_W'($urandom_range(6, 7))
                                               : OPC_W'($urandom_range(0, 5));
            if ($urandom_range(0, 3) == 0) begin
                // b is a scaled copy of a, so compare finds equality, subtract lands on
                // zero and divide on one unless the numerator is zero.
                sn = int'($urandom_range(0, 200)) - 100;
                sd = int'($urandom_range(1, 200)) * ($urandom_range(0, 1) ? 1 : -1);
                k  = int'($urandom_range(1, 9)) * ($urandom_range(0, 1) ? 1 : -1);
                an = FIELD_W'(sn);
                ad = FIELD_W'(sd);
                bn = FIELD_W'(sn * k);
                bd = FIELD_W'(sd * k);
            end else begin
                an = random_operand();
                ad = random_denominator();
                bn = ($urandom_range(0, 15) == 0) ? '0 : random_operand();
                bd = random_denominator();
            end
            send_word(opc, an, ad, bn, bd);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_basic_ops();
        send_word(OPC_ADD, 1, 2, 1, 3);
        send_word(OPC_SUB, 1, 2, 2, 4);
        send_word(OPC_MUL, -32'sd2, 3, 3, -32'sd4);
        send_word(OPC_DIV, 1, 2, -32'sd1, 4);
        send_word(OPC_NEG, 3, -32'sd6, 5, 7);
        send_word(OPC_NEG, 0, 5, 1, 1);
        send_word(OPC_CMP, 1, 3, 1, 2);
        send_word(OPC_CMP, 2, 4, -32'sd1, -32'sd2);
        send_word(OPC_CMP, 1, 2, 1, 3);
        send_word(OPC_UNDEF_LO, 1, 2, 3, 4);
        send_word(OPC_UNDEF_HI, 5, 0, 0, 0);
    endtask

    task automatic test_error_paths();
        send_word(OPC_ADD, 1, 0, 1, 1);
        // Negate ignores b, so its zero denominator is no error.
        send_word(OPC_NEG, 1, 2, 1, 0);
        send_word(OPC_CMP, 1, 2, 1, 0);
        send_word(OPC_DIV, 1, 0, 0, 5);
        send_word(OPC_DIV, 3, 4, 0, -32'sd5);
        send_word(OPC_MUL, 0, 0, 0, 0);
    endtask

    task automatic test_extreme_operands();
        send_word(OPC_ADD, 32'h8000_0000, 1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(OPC_SUB, 32'h7FFF_FFFF, 1, 32'h8000_0000, 1);
        send_word(OPC_MUL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(OPC_MUL, 32'h7FFF_FFFF, 1, 32'h8000_0000, 1);
        send_word(OPC_DIV, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(OPC_CMP, 32'h8000_0000, 32'h8000_0000, 1, 1);
        send_word(OPC_NEG, 32'h8000_0000, 1, 0, 0);
        send_word(OPC_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    endtask

    task automatic test_random_mix();
        allow_idle = 1'b1;
        run_random(600);
    endtask

    task automatic test_random_steady();
        allow_idle = 1'b0;
        run_random(150);
    endtask

    initial begin
        mismatches     = 0;
        results_seen   = 0;
        allow_idle     = 1'b1;
        i_rst_n        = 1'b0;
        op_if.valid    = 1'b0;
        op_if.opcode   = '0;
        op_if.a_num    = '0;
        op_if.a_den    = '0;
        op_if.b_num    = '0;
        op_if.b_den    = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_basic_ops();
        test_error_paths();
        test_extreme_operands();
        test_random_mix();
        test_random_steady();

        @(negedge i_clk);
        op_if.valid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+hdl
hdl/rau_pkg.sv
hdl/rau_if.sv
hdl/rau_gcd.sv
hdl/rau_div.sv
hdl/rau_dp.sv
hdl/rau_ctrl.sv
hdl/rational_arithmetic_unit.sv
hdl/rau_chk.sv
tb/sv/tb.sv
